// ===== design/ptrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task release scheduler package
// Shared types, codes and constants for the scheduler core and its units.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  localparam int TaskSlotsDef = 8;

  localparam int IdxW     = 3;
  localparam int PeriodW  = 16;
  localparam int TickW    = 10;
  localparam int CntW16   = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  // Divider: numerator 2*period_ms + d, denominator 2*d.
  localparam int NumW = 18;
  localparam int DenW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RUNNING     = 1'd0,
    REG_TICK_PERIOD = 1'd1
  } ptrs_reg_e;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_DONE = 2'd1,
    MODE_ADD  = 2'd2
  } ptrs_mode_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_STARTED = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    TBL_NOP      = 2'd0,
    TBL_TICK     = 2'd1,
    TBL_COMPLETE = 2'd2,
    TBL_ADD      = 2'd3
  } tbl_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_DIV,
    S_RESULT
  } ptrs_state_e;

  typedef struct packed {
    tbl_op_e             op;
    logic [PeriodW-1:0]  period;
  } tbl_cmd_t;

  typedef struct packed {
    slot_state_e         state;
    logic                rel_hit;
    logic [CntW16-1:0]   overrun;
  } tbl_view_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== design/ptrs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler period divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptrs_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ptrs_pkg::NumW-1:0] num_i,
  input  wire logic [ptrs_pkg::DenW-1:0] den_i,
  output ptrs_pkg::div_status_t          status_o,
  output logic [ptrs_pkg::NumW-1:0]      quo_o
);
  import ptrs_pkg::*;

  localparam int StepW = $clog2(NumW);

  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]  acc_q, acc_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [DenW:0]    trial;
  logic             ge;

  always_comb begin
    trial  = {rem_q, acc_q[NumW-1]};
    ge     = (trial >= {1'b0, den_q});
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    acc_d  = acc_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      rem_d  = '0;
      acc_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      acc_d = {acc_q[NumW-2:0], ge};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o         = acc_q;

endmodule
`default_nettype wire

// ===== design/ptrs_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler slot table
// Per-slot state and counters with a single-slot tick update unit.
// ----------------------------------------------------------------------------
module ptrs_table #(
  parameter int TASK_SLOTS = ptrs_pkg::TaskSlotsDef,
  localparam int SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SlotW-1:0] addr_i,
  input  ptrs_pkg::tbl_cmd_t    cmd_i,
  output ptrs_pkg::tbl_view_t   view_o
);
  import ptrs_pkg::*;

  localparam logic [CntW16-1:0] CntMax = '1;

  slot_state_e        status_q [TASK_SLOTS];
  logic [PeriodW-1:0] period_q [TASK_SLOTS];
  logic [CntW16-1:0]  elapsed_q [TASK_SLOTS];
  logic [CntW16-1:0]  overrun_q [TASK_SLOTS];

  slot_state_e       cur_state;
  logic [CntW16-1:0] cur_elapsed;
  logic [CntW16-1:0] elapsed_inc;
  logic [CntW16-1:0] overrun_inc;
  logic              rel_hit;

  always_comb begin
    cur_state   = status_q[addr_i];
    cur_elapsed = elapsed_q[addr_i];
    elapsed_inc = (cur_elapsed == CntMax) ? cur_elapsed : cur_elapsed + CntW16'(1);
    overrun_inc = (overrun_q[addr_i] == CntMax) ? CntMax
                                                : overrun_q[addr_i] + CntW16'(1);
    rel_hit     = (cur_state == ST_READY) && (elapsed_inc >= period_q[addr_i]);
  end

  assign view_o.state   = cur_state;
  assign view_o.rel_hit = rel_hit;
  assign view_o.overrun = overrun_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        status_q[i] <= ST_UNUSED;
      end
    end else begin
      unique case (cmd_i.op)
        TBL_TICK: begin
          if (rel_hit) begin
            status_q[addr_i] <= ST_STARTED;
          end
        end
        TBL_COMPLETE: status_q[addr_i] <= ST_READY;
        TBL_ADD:      status_q[addr_i] <= ST_READY;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      TBL_TICK: begin
        if (rel_hit) begin
          elapsed_q[addr_i] <= '0;
          overrun_q[addr_i] <= CntW16'(1);
        end else if (cur_state == ST_READY) begin
          elapsed_q[addr_i] <= elapsed_inc;
        end else if (cur_state == ST_STARTED) begin
          overrun_q[addr_i] <= overrun_inc;
        end
      end
      TBL_ADD: begin
        period_q[addr_i]  <= cmd_i.period;
        elapsed_q[addr_i] <= '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/periodic_task_release_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic task release scheduler core
// Time-triggered table of periodic task slots driven by tick, complete and
// add requests.
// ----------------------------------------------------------------------------
// Requests arrive on the in_* channel (valid/stall) and results leave on the
// out_* channel (valid/stall) through an output register. One request is
// worked on at a time; in_stall_o is high until its work is finished.
// A tick request walks the slot table one slot per cycle unless a stalled
// output register holds a release, and yields one result per released slot,
// the final one flagged by out_last_o. A tick while stopped, or an unused
// mode, yields nothing.
// An accepted add request runs the period division in an iterative divider
// that produces one quotient bit per cycle; when it is done the new slot is
// written to the table, and the result state then loads the output register.
// A refused add and a complete request go straight to the result state.
// The configuration port writes running and tick_period_ms; the user must
// do so only while idle, and the block itself does not enforce it.
// Reset marks every slot unused, clears the slot count and stops the block.
// When the receiver stalls, the result is held in the output register and
// the walk or the request waits until the register can be reloaded.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_core #(
  parameter int TASK_SLOTS = ptrs_pkg::TaskSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ptrs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ptrs_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    in_mode_i,
  input  wire logic [ptrs_pkg::IdxW-1:0]     in_task_index_i,
  input  wire logic [ptrs_pkg::PeriodW-1:0]  in_period_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               out_released_o,
  output logic [ptrs_pkg::IdxW-1:0]          out_slot_o,
  output logic                               out_accepted_o,
  output logic [ptrs_pkg::CntW16-1:0]        out_overrun_ticks_o,
  output logic                               out_last_o
);
  import ptrs_pkg::*;

  localparam int SlotW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TotalW = $clog2(TASK_SLOTS + 1);

  ptrs_state_e        state_q, state_d;
  logic               running_q;
  logic [TickW-1:0]   tick_q;
  ptrs_mode_e         mode_q, mode_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               acc_q, acc_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [SlotW-1:0]   ptr_q, ptr_d;
  logic               pend_v_q, pend_v_d;
  logic [IdxW-1:0]    pend_slot_q, pend_slot_d;

  logic               out_v_q, out_v_d;
  logic               out_rel_q, out_rel_d;
  logic [IdxW-1:0]    out_slot_q, out_slot_d;
  logic               out_acc_q, out_acc_d;
  logic [CntW16-1:0]  out_ovr_q, out_ovr_d;
  logic               out_last_q, out_last_d;

  ptrs_mode_e         mode_in;
  logic               accept;
  logic               add_ok_in;
  logic               idx_ok_q;
  logic               out_free;
  logic               last_ptr;
  logic               walk_go;
  logic               res_acc;
  logic [TickW-1:0]   divisor;

  logic [SlotW-1:0]   tbl_addr;
  tbl_cmd_t           tbl_cmd;
  tbl_view_t          tbl_view;
  logic               div_start;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  div_status_t        div_stat;
  logic [NumW-1:0]    div_quo;

  assign mode_in    = ptrs_mode_e'(in_mode_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign add_ok_in  = (32'(total_q) < 32'(TASK_SLOTS)) &&
                      (32'(in_task_index_i) < 32'(TASK_SLOTS));
  assign idx_ok_q   = (32'(idx_q) < 32'(TASK_SLOTS));
  assign out_free   = !out_v_q || !out_stall_i;
  assign last_ptr   = (ptr_q == SlotW'(TASK_SLOTS - 1));
  assign walk_go    = !(tbl_view.rel_hit && pend_v_q && !out_free);
  assign res_acc    = (mode_q == MODE_DONE) ? (idx_ok_q && tbl_view.state != ST_UNUSED)
                                            : acc_q;

  assign divisor   = (tick_q == '0) ? TickW'(1) : tick_q;
  assign div_num   = {1'b0, in_period_ms_i, 1'b0} + NumW'(divisor);
  assign div_den   = {divisor, 1'b0};
  assign div_start = accept && (mode_in == MODE_ADD) && add_ok_in;

  ptrs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_stat),
    .quo_o    (div_quo)
  );

  ptrs_table #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (tbl_addr),
    .cmd_i  (tbl_cmd),
    .view_o (tbl_view)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_in)
            MODE_TICK: state_d = running_q ? S_WALK : S_IDLE;
            MODE_DONE: state_d = S_RESULT;
            MODE_ADD:  state_d = add_ok_in ? S_DIV : S_RESULT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (walk_go && last_ptr) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d         = mode_q;
    idx_d          = idx_q;
    acc_d          = acc_q;
    total_d        = total_q;
    ptr_d          = ptr_q;
    pend_v_d       = pend_v_q;
    pend_slot_d    = pend_slot_q;
    tbl_addr       = (state_q == S_WALK) ? ptr_q : SlotW'(idx_q);
    tbl_cmd.op     = TBL_NOP;
    tbl_cmd.period = (div_quo[NumW-1:PeriodW] != '0) ? '1 : div_quo[PeriodW-1:0];
    out_v_d        = out_v_q && out_stall_i;
    out_rel_d      = out_rel_q;
    out_slot_d     = out_slot_q;
    out_acc_d      = out_acc_q;
    out_ovr_d      = out_ovr_q;
    out_last_d     = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d   = mode_in;
          idx_d    = in_task_index_i;
          acc_d    = 1'b0;
          ptr_d    = '0;
          pend_v_d = 1'b0;
        end
      end
      S_WALK: begin
        if (walk_go) begin
          tbl_cmd.op = TBL_TICK;
          ptr_d      = ptr_q + SlotW'(1);
          if (tbl_view.rel_hit) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_rel_d  = 1'b1;
              out_slot_d = pend_slot_q;
              out_acc_d  = 1'b0;
              out_ovr_d  = '0;
              out_last_d = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_slot_d = IdxW'(ptr_q);
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d    = 1'b1;
          out_rel_d  = 1'b1;
          out_slot_d = pend_slot_q;
          out_acc_d  = 1'b0;
          out_ovr_d  = '0;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          tbl_cmd.op = TBL_ADD;
          total_d    = total_q + TotalW'(1);
          acc_d      = 1'b1;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_rel_d  = 1'b0;
          out_slot_d = idx_q;
          out_acc_d  = res_acc;
          out_ovr_d  = (mode_q == MODE_DONE && res_acc) ? tbl_view.overrun : '0;
          out_last_d = 1'b1;
          if (mode_q == MODE_DONE && res_acc) begin
            tbl_cmd.op = TBL_COMPLETE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= 1'b0;
      tick_q    <= TickW'(1);
      total_q   <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      ptr_q     <= '0;
      mode_q    <= MODE_TICK;
      acc_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      ptr_q    <= ptr_d;
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      if (cfg_we_i) begin
        unique case (ptrs_reg_e'(cfg_index_i))
          REG_RUNNING:     running_q <= cfg_data_i[0];
          REG_TICK_PERIOD: tick_q    <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pend_slot_q <= pend_slot_d;
    out_rel_q   <= out_rel_d;
    out_slot_q  <= out_slot_d;
    out_acc_q   <= out_acc_d;
    out_ovr_q   <= out_ovr_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o         = out_v_q;
  assign out_released_o      = out_rel_q;
  assign out_slot_o          = out_slot_q;
  assign out_accepted_o      = out_acc_q;
  assign out_overrun_ticks_o = out_ovr_q;
  assign out_last_o          = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("Pending release left over after a tick walk.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_stat.done) |=> (state_q == S_RESULT && acc_q))
    else $error("Divider completion did not lead to an accepted add result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= 32'(TASK_SLOTS))
    else $error("Registered slot count exceeds the table size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !walk_go) |=> (state_q == S_WALK && $stable(ptr_q)))
    else $error("Tick walk advanced while a release could not be handed on.");

endmodule
`default_nettype wire
